>>> hdl/arp_pkg.sv
// ----------------------------------------------------------------------------
// ARP responder package
// Field widths, status codes, opcode and register indexes shared by the
// responder and its checker.
// ----------------------------------------------------------------------------
package arp_pkg;

	localparam int HW_W    = 16;
	localparam int IP_W    = 32;
	localparam int MAC_W   = 48;
	localparam int STAT_W  = 3;
	localparam int IN_W    = 208;
	localparam int OUT_W   = 168;
	localparam int CIDX_W  = 8;
	localparam int CDATA_W = 48;

	typedef logic [STAT_W-1:0] status_t;
	typedef logic [CIDX_W-1:0] cfg_idx_t;

	localparam status_t ST_BAD_HW    = 3'd0;
	localparam status_t ST_BAD_PROTO = 3'd1;
	localparam status_t ST_NOT_OURS  = 3'd2;
	localparam status_t ST_ACCEPTED  = 3'd3;
	localparam status_t ST_REPLY     = 3'd4;

	localparam logic [HW_W-1:0] OPCODE_REQUEST = 16'h0001;

	localparam cfg_idx_t REG_HW_TYPE    = 8'd0;
	localparam cfg_idx_t REG_PROTO_TYPE = 8'd1;
	localparam cfg_idx_t REG_MY_IP      = 8'd2;
	localparam cfg_idx_t REG_MY_MAC     = 8'd3;

	localparam logic [HW_W-1:0] HW_TYPE_RESET    = 16'h0001;
	localparam logic [HW_W-1:0] PROTO_TYPE_RESET = 16'h0800;

endpackage

>>> hdl/arp_responder_with_cache_top.sv
// ----------------------------------------------------------------------------
// ARP responder with IP-to-MAC cache
// Checks each received ARP packet, keeps a cache of sender addresses and
// builds a reply for requests aimed at the own address.
// ----------------------------------------------------------------------------
// Usage:
// The s_axis channel carries one received packet per transaction as fields.
// The m_axis channel returns exactly one result per packet: a status code,
// the cache-full flag and, for a reply, the swapped address fields.
// The cfg channel writes the expected hardware and protocol types and the
// own IP and MAC addresses; it is always ready and is to be used only
// while no packet is in flight.
// The cache IP memory is scanned one entry per cycle through its single
// read port, and a matching entry stops the scan early. One packet is
// processed at a time; a new one is accepted as soon as the previous
// result has been placed in the output register, even while that result
// waits. If the receiver stalls, the next finished result waits until the
// output register is free. Reset empties the cache by clearing the entry
// count and restores the register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_top #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// hw_type, proto_type, opcode, sender_mac, sender_ip, target_mac, target_ip
	input  logic [arp_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// status, cache_full, reply_sender_mac, reply_sender_ip,
	// reply_target_mac, reply_target_ip, four zero bits
	output logic [arp_pkg::OUT_W-1:0]       m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [arp_pkg::CIDX_W-1:0]      cfg_index,
	input  logic [arp_pkg::CDATA_W-1:0]     cfg_data
);
	import arp_pkg::*;

	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SEARCH,
		S_UPDATE,
		S_OUT
	} state_t;

	state_t state_q;

	logic [HW_W-1:0]  hw_exp_q, proto_exp_q;
	logic [IP_W-1:0]  my_ip_q;
	logic [MAC_W-1:0] my_mac_q;

	logic [HW_W-1:0]  hw_q, proto_q, op_q;
	logic [MAC_W-1:0] smac_q;
	logic [IP_W-1:0]  sip_q, tip_q;

	logic [IP_W-1:0]  cache_ip  [CACHE_ENTRIES];
	logic [MAC_W-1:0] cache_mac [CACHE_ENTRIES];

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] scan_q;
	logic [IP_W-1:0]  rd_data_s1;
	logic             rd_valid_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	status_t          status_q;
	logic             full_q;

	logic             issue;
	logic             for_us;
	logic             has_room;
	logic             ip_we, mac_we;
	logic [IDX_W-1:0] wr_addr;

	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_full_q;
	logic [MAC_W-1:0] out_rsm_q, out_rtm_q;
	logic [IP_W-1:0]  out_rsip_q, out_rtip_q;

	assign issue    = (state_q == S_SEARCH) && (scan_q < count_q);
	assign for_us   = (tip_q == my_ip_q);
	assign has_room = (count_q < CNT_W'(CACHE_ENTRIES));

	assign ip_we   = (state_q == S_UPDATE) && !hit_q && for_us && has_room;
	assign mac_we  = (state_q == S_UPDATE) && (hit_q || (for_us && has_room));
	assign wr_addr = hit_q ? hit_idx_q : count_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		rd_data_s1 <= cache_ip[scan_q[IDX_W-1:0]];
		if (ip_we) begin
			cache_ip[wr_addr] <= sip_q;
		end
		if (mac_we) begin
			cache_mac[wr_addr] <= smac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_exp_q    <= HW_TYPE_RESET;
			proto_exp_q <= PROTO_TYPE_RESET;
			my_ip_q     <= '0;
			my_mac_q    <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_HW_TYPE:    hw_exp_q    <= cfg_data[HW_W-1:0];
				REG_PROTO_TYPE: proto_exp_q <= cfg_data[HW_W-1:0];
				REG_MY_IP:      my_ip_q     <= cfg_data[IP_W-1:0];
				REG_MY_MAC:     my_mac_q    <= cfg_data[MAC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			hw_q    <= s_axis_tdata[15:0];
			proto_q <= s_axis_tdata[31:16];
			op_q    <= s_axis_tdata[47:32];
			smac_q  <= s_axis_tdata[95:48];
			sip_q   <= s_axis_tdata[127:96];
			tip_q   <= s_axis_tdata[207:176];
		end
		rd_idx_s1 <= scan_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			scan_q       <= '0;
			rd_valid_s1  <= 1'b0;
			hit_q        <= 1'b0;
			hit_idx_q    <= '0;
			status_q     <= ST_BAD_HW;
			full_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_BAD_HW;
			out_full_q   <= 1'b0;
			out_rsm_q    <= '0;
			out_rsip_q   <= '0;
			out_rtm_q    <= '0;
			out_rtip_q   <= '0;
		end else begin
			if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			rd_valid_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					full_q <= 1'b0;
					hit_q  <= 1'b0;
					scan_q <= '0;
					if (hw_q != hw_exp_q) begin
						status_q <= ST_BAD_HW;
						state_q  <= S_OUT;
					end else if (proto_q != proto_exp_q) begin
						status_q <= ST_BAD_PROTO;
						state_q  <= S_OUT;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					if (issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (rd_valid_s1 && (rd_data_s1 == sip_q)) begin
						hit_q     <= 1'b1;
						hit_idx_q <= rd_idx_s1;
						state_q   <= S_UPDATE;
					end else if (!issue && !rd_valid_s1) begin
						state_q <= S_UPDATE;
					end else begin
						rd_valid_s1 <= issue;
					end
				end
				S_UPDATE: begin
					if (!for_us) begin
						status_q <= ST_NOT_OURS;
					end else begin
						if (!hit_q) begin
							if (has_room) begin
								count_q <= count_q + CNT_W'(1);
							end else begin
								full_q <= 1'b1;
							end
						end
						status_q <= (op_q == OPCODE_REQUEST) ? ST_REPLY : ST_ACCEPTED;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= status_q;
						out_full_q   <= full_q;
						if (status_q == ST_REPLY) begin
							out_rsm_q  <= my_mac_q;
							out_rsip_q <= tip_q;
							out_rtm_q  <= smac_q;
							out_rtip_q <= sip_q;
						end else begin
							out_rsm_q  <= '0;
							out_rsip_q <= '0;
							out_rtm_q  <= '0;
							out_rtip_q <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0000, out_rtip_q, out_rtm_q, out_rsip_q, out_rsm_q,
		out_full_q, out_status_q};

endmodule

>>> hdl/arp_chk.sv
// ----------------------------------------------------------------------------
// ARP responder checker
// Port-level properties of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module arp_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [arp_pkg::IN_W-1:0]    s_axis_tdata,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [arp_pkg::OUT_W-1:0]   m_axis_tdata,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic [arp_pkg::CIDX_W-1:0]  cfg_index,
	input logic [arp_pkg::CDATA_W-1:0] cfg_data
);
	import arp_pkg::*;

	// A stalled result transaction keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] == ST_BAD_HW)
			|| (m_axis_tdata[2:0] == ST_BAD_PROTO)
			|| (m_axis_tdata[2:0] == ST_NOT_OURS)
			|| (m_axis_tdata[2:0] == ST_ACCEPTED)
			|| (m_axis_tdata[2:0] == ST_REPLY))
		else $error("status code out of range");

	// The cache-full flag only accompanies a packet aimed at us.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[3] |->
			(m_axis_tdata[2:0] == ST_ACCEPTED) || (m_axis_tdata[2:0] == ST_REPLY))
		else $error("cache full flagged on a packet that needs no insert");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] != ST_REPLY) |-> (m_axis_tdata[167:4] == '0))
		else $error("reply fields set without a reply");

endmodule

bind arp_responder_with_cache_top arp_chk u_arp_chk (.*);

>>> tb/arp_responder_with_cache_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder with cache testbench
// Drives received ARP packets into the responder and checks every result
// against a cycle-free prediction of the status, the cache-full flag and the
// reply fields. A directed part covers register and field extremes, rejects,
// packets not aimed at us, cache hits and a full cache; random phases run under
// four register settings, the last three with random gaps on both streams.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_top_tb;

	import arp_pkg::*;

	localparam int CACHE_ENTRIES  = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 40;
	localparam int MAX_GAP        = 14;

	localparam logic [HW_W-1:0] OPCODE_REPLY     = 16'h0002;
	localparam cfg_idx_t        REG_FIRST_UNUSED = 8'd4;
	localparam cfg_idx_t        REG_LAST_UNUSED  = 8'hff;

	typedef struct packed {
		logic [IP_W-1:0]  target_ip;
		logic [MAC_W-1:0] target_mac;
		logic [IP_W-1:0]  sender_ip;
		logic [MAC_W-1:0] sender_mac;
		logic [HW_W-1:0]  opcode;
		logic [HW_W-1:0]  proto_type;
		logic [HW_W-1:0]  hw_type;
	} arp_packet_t;

	typedef struct packed {
		logic [3:0]       padding;
		logic [IP_W-1:0]  reply_target_ip;
		logic [MAC_W-1:0] reply_target_mac;
		logic [IP_W-1:0]  reply_sender_ip;
		logic [MAC_W-1:0] reply_sender_mac;
		logic             cache_full;
		status_t          status;
	} arp_result_t;

	logic               clk;
	logic               arst_n;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [IN_W-1:0]    s_axis_tdata;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [OUT_W-1:0]   m_axis_tdata;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CIDX_W-1:0]  cfg_index;
	logic [CDATA_W-1:0] cfg_data;

	logic [HW_W-1:0]  acc_hw_type;
	logic [HW_W-1:0]  acc_proto_type;
	logic [IP_W-1:0]  own_ip;
	logic [MAC_W-1:0] own_mac;
	logic [IP_W-1:0]  cached_ip [CACHE_ENTRIES];
	logic [MAC_W-1:0] cached_mac [CACHE_ENTRIES];
	int               cached_count;

	arp_result_t awaited_results[$];
	arp_result_t got_result;
	arp_result_t want_result;
	int          mismatches;
	int          quiet_cycles;
	bit          idle_on;

	arp_responder_with_cache_top #(
		.CACHE_ENTRIES(CACHE_ENTRIES)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [MAC_W-1:0] rand_mac();
		return MAC_W'({$urandom, $urandom});
	endfunction

	function automatic int find_cached(logic [IP_W-1:0] ip);
		for (int i = 0; i < cached_count; i++) begin
			if (cached_ip[i] == ip)
				return i;
		end
		return -1;
	endfunction

	function automatic logic [IP_W-1:0] fresh_ip();
		logic [IP_W-1:0] ip;
		do
			ip = $urandom;
		while (find_cached(ip) >= 0);
		return ip;
	endfunction

	function automatic arp_packet_t build_packet(logic [HW_W-1:0] hw, logic [HW_W-1:0] proto,
		logic [HW_W-1:0] op, logic [MAC_W-1:0] smac, logic [IP_W-1:0] sip,
		logic [MAC_W-1:0] tmac, logic [IP_W-1:0] tip);
		arp_packet_t pkt;
		pkt.hw_type    = hw;
		pkt.proto_type = proto;
		pkt.opcode     = op;
		pkt.sender_mac = smac;
		pkt.sender_ip  = sip;
		pkt.target_mac = tmac;
		pkt.target_ip  = tip;
		return pkt;
	endfunction

	// Works out the result of one packet and updates the cache copy.
	function automatic arp_result_t answer_packet(arp_packet_t pkt);
		arp_result_t res;
		int          hit;
		res = '0;
		if (pkt.hw_type != acc_hw_type) begin
			res.status = ST_BAD_HW;
		end else if (pkt.proto_type != acc_proto_type) begin
			res.status = ST_BAD_PROTO;
		end else begin
			hit = find_cached(pkt.sender_ip);
			if (hit >= 0)
				cached_mac[hit] = pkt.sender_mac;
			if (pkt.target_ip != own_ip) begin
				res.status = ST_NOT_OURS;
			end else begin
				if (hit < 0) begin
					if (cached_count < CACHE_ENTRIES) begin
						cached_ip[cached_count]  = pkt.sender_ip;
						cached_mac[cached_count] = pkt.sender_mac;
						cached_count++;
					end else begin
						res.cache_full = 1'b1;
					end
				end
				if (pkt.opcode == OPCODE_REQUEST) begin
					res.status           = ST_REPLY;
					res.reply_sender_mac = own_mac;
					res.reply_sender_ip  = pkt.target_ip;
					res.reply_target_mac = pkt.sender_mac;
					res.reply_target_ip  = pkt.sender_ip;
				end else begin
					res.status = ST_ACCEPTED;
				end
			end
		end
		return res;
	endfunction

	function automatic void apply_register(cfg_idx_t idx, logic [CDATA_W-1:0] val);
		case (idx)
			REG_HW_TYPE: begin
				acc_hw_type = val[HW_W-1:0];
			end
			REG_PROTO_TYPE: begin
				acc_proto_type = val[HW_W-1:0];
			end
			REG_MY_IP: begin
				own_ip = val[IP_W-1:0];
			end
			REG_MY_MAC: begin
				own_mac = val[MAC_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			mismatches++;
		end
	endfunction

	function automatic arp_packet_t random_packet();
		arp_packet_t pkt;
		int          sel;
		pkt = build_packet(acc_hw_type, acc_proto_type, OPCODE_REQUEST, rand_mac(), $urandom,
			rand_mac(), own_ip);
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			pkt.hw_type = HW_W'($urandom);
			if (pkt.hw_type == acc_hw_type)
				pkt.hw_type = ~pkt.hw_type;
		end else if (sel < 16) begin
			pkt.proto_type = HW_W'($urandom);
			if (pkt.proto_type == acc_proto_type)
				pkt.proto_type = ~pkt.proto_type;
		end
		sel = $urandom_range(0, 99);
		if (sel < 20)
			pkt.opcode = OPCODE_REPLY;
		else if (sel < 40)
			pkt.opcode = HW_W'($urandom);
		sel = $urandom_range(0, 99);
		if (sel < 50 && cached_count > 0)
			pkt.sender_ip = cached_ip[$urandom_range(0, cached_count - 1)];
		else if (sel < 58)
			pkt.sender_ip = own_ip;
		if ($urandom_range(0, 99) < 35)
			pkt.target_ip = $urandom;
		return pkt;
	endfunction

	task automatic send_packet(input arp_packet_t pkt);
		int gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= pkt;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		awaited_results.push_back(answer_packet(pkt));
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four registers, with random bits above the narrower ones,
	// and optionally a final write to an index that does not exist.
	task automatic configure(input logic [HW_W-1:0] hw, input logic [HW_W-1:0] proto,
		input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac, input bit poke_unused);
		cfg_idx_t           idx;
		logic [CDATA_W-1:0] val;
		int                 writes;
		writes = poke_unused ? 5 : 4;
		for (int k = 0; k < writes; k++) begin
			val = rand_mac();
			case (k)
				0: begin
					idx = REG_HW_TYPE;
					val[HW_W-1:0] = hw;
				end
				1: begin
					idx = REG_PROTO_TYPE;
					val[HW_W-1:0] = proto;
				end
				2: begin
					idx = REG_MY_IP;
					val[IP_W-1:0] = ip;
				end
				3: begin
					idx = REG_MY_MAC;
					val = mac;
				end
				default: begin
					idx = cfg_idx_t'($urandom_range(REG_FIRST_UNUSED, REG_LAST_UNUSED));
				end
			endcase
			cfg_index <= idx;
			cfg_data  <= val;
			cfg_valid <= 1'b1;
			do
				@(posedge clk);
			while (!cfg_ready);
			apply_register(idx, val);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		idle_on = 1'b1;
		send_packet(build_packet(HW_TYPE_RESET, PROTO_TYPE_RESET, OPCODE_REQUEST, rand_mac(),
			fresh_ip(), rand_mac(), '0));
		send_packet(build_packet(~HW_TYPE_RESET, PROTO_TYPE_RESET, OPCODE_REQUEST, rand_mac(),
			$urandom, rand_mac(), '0));
		send_packet(build_packet(HW_TYPE_RESET, ~PROTO_TYPE_RESET, OPCODE_REQUEST, rand_mac(),
			$urandom, rand_mac(), '0));
	endtask

	task automatic test_register_extremes();
		wait_drained();
		configure('1, '1, '1, '1, 1'b1);
		send_packet(build_packet('1, '1, OPCODE_REQUEST, '1, '1, '1, '1));
		send_packet(build_packet('1, '1, '1, '0, '1, '0, '1));
		wait_drained();
		configure('0, '0, '0, '0, 1'b1);
		send_packet(build_packet('0, '0, '0, '0, '0, '0, '0));
		send_packet(build_packet('0, '0, OPCODE_REQUEST, rand_mac(), '0, rand_mac(), '0));
	endtask

	task automatic test_packet_cases();
		logic [IP_W-1:0] known_ip;
		wait_drained();
		configure(HW_TYPE_RESET, PROTO_TYPE_RESET, $urandom, rand_mac(), 1'b0);
		known_ip = fresh_ip();
		send_packet(build_packet(acc_hw_type ^ 16'h8000, acc_proto_type, OPCODE_REQUEST,
			rand_mac(), known_ip, rand_mac(), own_ip));
		send_packet(build_packet(acc_hw_type, acc_proto_type ^ 16'h0001, OPCODE_REQUEST,
			rand_mac(), known_ip, rand_mac(), own_ip));
		send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REQUEST, rand_mac(),
			fresh_ip(), rand_mac(), ~own_ip));
		send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REQUEST, rand_mac(),
			known_ip, rand_mac(), own_ip));
		send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REQUEST, rand_mac(),
			known_ip, rand_mac(), own_ip ^ 32'h1));
		send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REPLY, rand_mac(),
			known_ip, rand_mac(), own_ip));
		while (cached_count < CACHE_ENTRIES)
			send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REQUEST, rand_mac(),
				fresh_ip(), rand_mac(), own_ip));
		send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REQUEST, rand_mac(),
			fresh_ip(), rand_mac(), own_ip));
		send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REPLY, rand_mac(),
			fresh_ip(), rand_mac(), own_ip));
		send_packet(build_packet(acc_hw_type, acc_proto_type, OPCODE_REQUEST, rand_mac(),
			known_ip, rand_mac(), own_ip));
	endtask

	// Random traffic under one register setting; halfway through, the sender
	// holds off until every outstanding result has been returned.
	task automatic test_random_traffic(input int count, input bit with_idle,
		input logic [HW_W-1:0] hw, input logic [HW_W-1:0] proto,
		input logic [IP_W-1:0] ip, input logic [MAC_W-1:0] mac);
		wait_drained();
		idle_on = with_idle;
		configure(hw, proto, ip, mac, 1'b1);
		for (int i = 0; i < count; i++) begin
			if (i == count / 2)
				wait_drained();
			send_packet(random_packet());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		idle_on       = 1'b1;
		mismatches    = 0;
		acc_hw_type    = HW_TYPE_RESET;
		acc_proto_type = PROTO_TYPE_RESET;
		own_ip         = '0;
		own_mac        = '0;
		cached_count   = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_packet_cases();
		test_random_traffic(480, 1'b0, HW_W'($urandom), HW_W'($urandom), $urandom, rand_mac());
		test_random_traffic(480, 1'b1, HW_TYPE_RESET, PROTO_TYPE_RESET, $urandom, rand_mac());
		test_random_traffic(480, 1'b1, '1, '1, '1, '1);
		test_random_traffic(480, 1'b1, '0, '0, '0, '0);
		wait_drained();
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			int stall;
			stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_result = arp_result_t'(m_axis_tdata);
			if (awaited_results.size() == 0) begin
				$error("result with nothing outstanding: %0h", m_axis_tdata);
				mismatches++;
			end else begin
				want_result = awaited_results.pop_front();
				check_field("status", want_result.status, got_result.status);
				check_field("cache_full", want_result.cache_full, got_result.cache_full);
				check_field("reply_sender_mac", want_result.reply_sender_mac,
					got_result.reply_sender_mac);
				check_field("reply_sender_ip", want_result.reply_sender_ip,
					got_result.reply_sender_ip);
				check_field("reply_target_mac", want_result.reply_target_mac,
					got_result.reply_target_mac);
				check_field("reply_target_ip", want_result.reply_target_ip,
					got_result.reply_target_ip);
				check_field("padding", want_result.padding, got_result.padding);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
			|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
